// ===== hw/rtl/supg_upwind_diffusivity_defines.svh =====
// Assertion helpers shared by the block's RTL.
`ifndef SUPG_UPWIND_DIFFUSIVITY_DEFINES_SVH
`define SUPG_UPWIND_DIFFUSIVITY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SUPG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SUPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/supg_pkg.sv =====
`default_nettype none
package supg_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_DIMS_DEF  = 3;
   localparam int CF_DEPTH      = 40;

   localparam logic [31:0] ISQRT15_Q32 = 32'd1108955787;
   localparam logic [63:0] MASK31      = 64'h0000_0000_7FFF_FFFF;

   // register indexes
   localparam logic [1:0] CSR_XI_METHOD  = 2'd0;
   localparam logic [1:0] CSR_NUM_DIMS   = 2'd1;
   localparam logic [1:0] CSR_MIN_DIFF   = 2'd2;

   // upwind forms
   localparam logic [1:0] XI_EXACT    = 2'd0;
   localparam logic [1:0] XI_DOUBLE   = 2'd1;
   localparam logic [1:0] XI_CRITICAL = 2'd2;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        len_x;
      logic [30:0]        len_y;
      logic [30:0]        len_z;
      logic [30:0]        diffusivity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] upwind_diffusivity;
      logic [30:0]        max_seen;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/supg_upwind_diffusivity.sv =====
// SUPG upwind diffusivity, one element per word.
// Request channel (req_valid/req_stall/req_data) takes one element: velocity,
// edge length per axis and raw diffusivity. Response channel
// (rsp_valid/rsp_stall/rsp_data) returns the upwind diffusivity and the
// largest raw diffusivity seen since reset. One response per request.
// All arithmetic runs on one 32x32 multiplier and one radix-2 restoring
// divider under a sequencer; the block takes a new word only when idle.
// Per axis: a multiply and a divide for the Peclet number, then a constant
// xi, an m/3 reciprocal multiply, a reciprocal divide, or the exact continued
// fraction (40 divides), then a multiply-accumulate for the term. A scaling
// multiply follows the last axis; the response is then registered, and the
// block returns to idle once it is taken.
// The response sits in an output register until taken; while rsp_stall is
// high it holds and no new request is accepted.
// csr_we writes xi_method, num_dims or min_diffusivity at csr_index; write
// only while idle. Synchronous reset restores xi_method 0, num_dims 2,
// min_diffusivity 1 and clears the running maximum.
`default_nettype none
`include "supg_upwind_diffusivity_defines.svh"
module supg_upwind_diffusivity #(
   parameter int FRAC_BITS = supg_pkg::FRAC_BITS_DEF,
   parameter int MAX_DIMS  = supg_pkg::MAX_DIMS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire supg_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output supg_pkg::rsp_type     rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [30:0]      csr_wdata
);
   import supg_pkg::*;

   localparam logic [63:0] ONE    = 64'd1 << FRAC_BITS;
   localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);
   localparam int          D_W    = $clog2(2 * CF_DEPTH);
   localparam logic [D_W-1:0] D_TOP  = D_W'(2 * CF_DEPTH - 1);
   localparam logic [D_W-1:0] D_LAST = D_W'(3);
   localparam logic [1:0]  DIMS_MAX = 2'(MAX_DIMS);
   // ceil(2^33 / 3): floor(m * RECIP3 / 2^33) is m / 3 for any 32-bit m
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

   typedef enum logic [4:0] {
      S_IDLE, A_MUL, A_PEC, A_PECD, X_MUL3, X_DIV3, X_RECIP, E_SQ, E_A2, E_CFS,
      E_CF, E_FIN, T_MUL1, T_MUL2, T_ACC, S_SC1, S_SC2, S_SC3, S_OUT, S_DIV
   } state_type;

   state_type   state_ff, ret_ff;
   logic [1:0]  xi_method_ff, num_dims_ff, dims_ff, axis_ff;
   logic [30:0] min_diff_ff, max_seen_ff, k_ff;
   req_type     req_ff;
   rsp_type     rsp_ff;
   logic [63:0] prod_ff, p_ff, acc_ff, sum_ff, a2s_ff;
   logic [30:0] m_ff;
   logic [31:0] xi_ff;
   logic [32:0] t_ff;
   logic [D_W-1:0] d_ff;
   // divider
   logic [32:0] div_rem_ff, div_den_ff;
   logic [63:0] div_quo_ff;
   logic [6:0]  div_cnt_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_in;
   logic [33:0] div_r2;
   logic        div_ge;
   logic [33:0] div_rem_in;
   logic [31:0] vm;
   logic [30:0] h_sel;
   logic signed [31:0] v_sel;
   logic [30:0] m_in, kmin, k_in;
   logic [1:0]  dims_in;
   logic [63:0] pfrac, term_in, res_in;
   logic [32:0] t_in;

   always_comb begin
      unique case (axis_ff)
         2'd0:    begin v_sel = req_ff.vel_x; h_sel = req_ff.len_x; end
         2'd1:    begin v_sel = req_ff.vel_y; h_sel = req_ff.len_y; end
         default: begin v_sel = req_ff.vel_z; h_sel = req_ff.len_z; end
      endcase
   end
   assign vm    = v_sel[31] ? (~v_sel + 32'd1) : v_sel;
   assign pfrac = p_ff >> FRAC_BITS;

   always_comb begin
      unique case (state_ff)
         A_MUL:   begin mul_a = vm;           mul_b = {1'b0, h_sel}; end
         X_MUL3:  begin mul_a = {1'b0, m_ff}; mul_b = RECIP3; end
         E_SQ:    begin mul_a = {1'b0, m_ff}; mul_b = {1'b0, m_ff}; end
         T_MUL1:  begin mul_a = pfrac[31:0];  mul_b = xi_ff; end
         T_MUL2:  begin mul_a = pfrac[63:32]; mul_b = xi_ff; end
         S_SC1:   begin mul_a = sum_ff[31:0]; mul_b = ISQRT15_Q32; end
         S_SC2:   begin mul_a = sum_ff[63:32]; mul_b = ISQRT15_Q32; end
         default: begin mul_a = '0;           mul_b = '0; end
      endcase
   end
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   assign div_r2     = {div_rem_ff, div_quo_ff[63]};
   assign div_ge     = div_r2 >= {1'b0, div_den_ff};
   assign div_rem_in = div_ge ? (div_r2 - {1'b0, div_den_ff}) : div_r2;

   assign m_in    = (div_quo_ff > MASK31) ? 31'h7FFF_FFFF : div_quo_ff[30:0];
   assign kmin    = (min_diff_ff == 31'd0) ? 31'd1 : min_diff_ff;
   assign k_in    = (req_data.diffusivity > kmin) ? req_data.diffusivity : kmin;
   assign dims_in = (num_dims_ff == 2'd0) ? 2'd1 :
                    ((num_dims_ff > DIMS_MAX) ? DIMS_MAX : num_dims_ff);
   // wraps like a 64-bit product would
   assign term_in = ({prod_ff[31:0], 32'd0} + acc_ff) >> FRAC_BITS;
   assign res_in  = prod_ff + (acc_ff >> 32);
   assign t_in    = 33'((64'(d_ff) << FRAC_BITS) + div_quo_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         xi_method_ff <= XI_EXACT;
         num_dims_ff  <= 2'd2;
         min_diff_ff  <= 31'd1;
         max_seen_ff  <= '0;
         div_cnt_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_XI_METHOD: xi_method_ff <= csr_wdata[1:0];
               CSR_NUM_DIMS:  num_dims_ff  <= csr_wdata[1:0];
               CSR_MIN_DIFF:  min_diff_ff  <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff  <= req_data;
                  k_ff    <= k_in;
                  dims_ff <= dims_in;
                  axis_ff <= 2'd0;
                  sum_ff  <= '0;
                  if (req_data.diffusivity > max_seen_ff)
                     max_seen_ff <= req_data.diffusivity;
                  state_ff <= A_MUL;
               end
            end
            A_MUL: state_ff <= A_PEC;
            A_PEC: begin
               p_ff       <= prod_ff;
               div_rem_ff <= '0;
               div_quo_ff <= prod_ff;
               div_den_ff <= {1'b0, k_ff, 1'b0};
               div_cnt_ff <= 7'd64;
               ret_ff     <= A_PECD;
               state_ff   <= S_DIV;
            end
            A_PECD: begin
               m_ff <= m_in;
               priority if (xi_method_ff == XI_DOUBLE) begin
                  if (64'(m_in) <= 3 * ONE) begin
                     state_ff <= X_MUL3;
                  end else begin
                     xi_ff    <= ONE[31:0];
                     state_ff <= T_MUL1;
                  end
               end else if (xi_method_ff == XI_CRITICAL || 64'(m_in) > 20 * ONE) begin
                  if (xi_method_ff == XI_CRITICAL && 64'(m_in) <= ONE) begin
                     xi_ff    <= '0;
                     state_ff <= T_MUL1;
                  end else begin
                     div_rem_ff <= '0;
                     div_quo_ff <= ONE_SQ;
                     div_den_ff <= {2'b0, m_in};
                     div_cnt_ff <= 7'd64;
                     ret_ff     <= X_RECIP;
                     state_ff   <= S_DIV;
                  end
               end else if (m_in == 31'd0) begin
                  xi_ff    <= '0;
                  state_ff <= T_MUL1;
               end else begin
                  state_ff <= E_SQ;
               end
            end
            X_MUL3: state_ff <= X_DIV3;
            X_DIV3: begin
               xi_ff    <= 32'(prod_ff >> 33);
               state_ff <= T_MUL1;
            end
            X_RECIP: begin
               xi_ff    <= 32'(ONE - div_quo_ff);
               state_ff <= T_MUL1;
            end
            E_SQ: state_ff <= E_A2;
            E_A2: begin
               a2s_ff   <= (prod_ff >> FRAC_BITS) << FRAC_BITS;
               t_ff     <= 33'(64'(2 * CF_DEPTH + 1) << FRAC_BITS);
               d_ff     <= D_TOP;
               state_ff <= E_CFS;
            end
            E_CFS: begin
               div_rem_ff <= '0;
               div_quo_ff <= a2s_ff;
               div_den_ff <= t_ff;
               div_cnt_ff <= 7'd64;
               ret_ff     <= E_CF;
               state_ff   <= S_DIV;
            end
            E_CF: begin
               if (d_ff == D_LAST) begin
                  div_rem_ff <= '0;
                  div_quo_ff <= 64'(m_ff) << FRAC_BITS;
                  div_den_ff <= t_in;
                  div_cnt_ff <= 7'd64;
                  ret_ff     <= E_FIN;
                  state_ff   <= S_DIV;
               end else begin
                  t_ff     <= t_in;
                  d_ff     <= d_ff - D_W'(2);
                  state_ff <= E_CFS;
               end
            end
            E_FIN: begin
               xi_ff    <= div_quo_ff[31:0];
               state_ff <= T_MUL1;
            end
            T_MUL1: state_ff <= T_MUL2;
            T_MUL2: begin
               acc_ff   <= prod_ff;
               state_ff <= T_ACC;
            end
            T_ACC: begin
               sum_ff <= sum_ff + term_in;
               if (axis_ff + 2'd1 == dims_ff) begin
                  state_ff <= S_SC1;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= A_MUL;
               end
            end
            S_SC1: state_ff <= S_SC2;
            S_SC2: begin
               acc_ff   <= prod_ff;
               state_ff <= S_SC3;
            end
            S_SC3: begin
               rsp_ff.upwind_diffusivity <= (res_in > MASK31) ? 32'h7FFF_FFFF :
                                                                res_in[31:0];
               rsp_ff.max_seen <= max_seen_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall)
                  state_ff <= S_IDLE;
            end
            S_DIV: begin
               div_rem_ff <= div_rem_in[32:0];
               div_quo_ff <= {div_quo_ff[62:0], div_ge};
               div_cnt_ff <= div_cnt_ff - 7'd1;
               if (div_cnt_ff == 7'd1)
                  state_ff <= ret_ff;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   `SUPG_ASSERT_NOW(a_div_count, state_ff == S_DIV, div_cnt_ff != 7'd0, "divider count ran out")
   `SUPG_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, !rsp_valid && req_stall, "accept did not start work")
   `SUPG_ASSERT_NOW(a_rsp_nonneg, rsp_valid, !rsp_data.upwind_diffusivity[31], "negative result")
   `SUPG_ASSERT_NOW(a_axis_range, state_ff == T_ACC, axis_ff < dims_ff, "axis past count")

endmodule
`default_nettype wire
